@@ sv/psss_pkg.sv @@
package psss_pkg;

    localparam int FRAME_BITS_DEF = 64;
    localparam int CUR_FRAME_W    = 64;
    localparam int DELAY_W        = 48;
    localparam int MODE_W         = 3;
    localparam int PHASE_W        = 3;
    localparam int LEN_W          = 13;
    localparam int OFF_W          = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 13;

    localparam logic [LEN_W-1:0] MAX_QUANTUM   = 13'd4096;
    localparam logic [LEN_W-1:0] QUANTUM_RESET = 13'd128;
    localparam logic [LEN_W-1:0] FADE_RESET    = 13'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUANTUM  = 2'd0,
        CFG_FADE_IN  = 2'd1,
        CFG_FADE_OUT = 2'd2
    } cfg_index_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 3'd0,
        MODE_START  = 3'd1,
        MODE_STOP   = 3'd2,
        MODE_RESET  = 3'd3,
        MODE_FINISH = 3'd4
    } mode_t;

    typedef enum logic [7:0] {
        PH_UNSCHED   = 8'b0000_0001,
        PH_SCHED     = 8'b0000_0010,
        PH_FADEIN    = 8'b0000_0100,
        PH_PLAYING   = 8'b0000_1000,
        PH_STOPPING  = 8'b0001_0000,
        PH_RESETTING = 8'b0010_0000,
        PH_FINISHING = 8'b0100_0000,
        PH_FINISHED  = 8'b1000_0000
    } phase_t;

    // phase as reported on the result channel
    typedef enum logic [PHASE_W-1:0] {
        PS_UNSCHED   = 3'd0,
        PS_SCHED     = 3'd1,
        PS_FADEIN    = 3'd2,
        PS_PLAYING   = 3'd3,
        PS_STOPPING  = 3'd4,
        PS_RESETTING = 3'd5,
        PS_FINISHING = 3'd6,
        PS_FINISHED  = 3'd7
    } phase_code_t;

    typedef struct packed {
        logic                 processed;
        logic [PHASE_W-1:0]   phase;
        logic [OFF_W-1:0]     render_offset;
        logic [LEN_W-1:0]     render_length;
        logic                 silence_all;
        logic                 fade_in_active;
        logic [LEN_W-1:0]     fade_in_end;
        logic                 fade_out_active;
        logic [LEN_W-1:0]     fade_out_start;
        logic [LEN_W-1:0]     fade_out_end;
        logic                 ended_event;
        logic                 start_notice;
    } result_t;

    function automatic logic [PHASE_W-1:0] phase_code(phase_t p);
        phase_code_t c;
        unique case (p)
            PH_UNSCHED:   c = PS_UNSCHED;
            PH_SCHED:     c = PS_SCHED;
            PH_FADEIN:    c = PS_FADEIN;
            PH_PLAYING:   c = PS_PLAYING;
            PH_STOPPING:  c = PS_STOPPING;
            PH_RESETTING: c = PS_RESETTING;
            PH_FINISHING: c = PS_FINISHING;
            PH_FINISHED:  c = PS_FINISHED;
            default:      c = PS_UNSCHED;
        endcase
        return c;
    endfunction

endpackage

@@ sv/playback_start_stop_scheduler.sv @@
// Start/stop scheduler for one audio source. Each transaction on the s_ channel is a quantum
// tick (mode 0, carrying the current frame) or a start, stop, reset or finish command, and
// gives exactly one transaction on the m_ channel. A tick later than the last epoch reports
// the new phase, the rendered span of the quantum and the fade-in/fade-out windows clamped to
// the quantum; stale ticks and commands report zeros apart from the ended and start flags.
// One item is taken every cycle while the m_ channel is not stalled. An accepted item waits in
// the input register; as it moves on, the phase and frame registers are updated and its result
// is registered in the output register, which drives the m_ channel. Registers are written
// through the cfg_ channel, which is always ready; the user must write them only while no item
// is in flight, as the block itself does not enforce it.
module playback_start_stop_scheduler #(
    parameter int FRAME_BITS = psss_pkg::FRAME_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [psss_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [psss_pkg::CFG_DATA_W-1:0]       cfg_data,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [psss_pkg::MODE_W-1:0]           s_mode,
    input  logic [psss_pkg::CUR_FRAME_W-1:0]      s_current_frame,
    input  logic signed [psss_pkg::DELAY_W-1:0]   s_delay_frames,
    input  logic                                  s_cancel,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_processed,
    output logic [psss_pkg::PHASE_W-1:0]          m_phase,
    output logic [psss_pkg::OFF_W-1:0]            m_render_offset,
    output logic [psss_pkg::LEN_W-1:0]            m_render_length,
    output logic                                  m_silence_all,
    output logic                                  m_fade_in_active,
    output logic [psss_pkg::LEN_W-1:0]            m_fade_in_end,
    output logic                                  m_fade_out_active,
    output logic [psss_pkg::LEN_W-1:0]            m_fade_out_start,
    output logic [psss_pkg::LEN_W-1:0]            m_fade_out_end,
    output logic                                  m_ended_event,
    output logic                                  m_start_notice
);

    logic [psss_pkg::LEN_W-1:0] quantum_reg, fade_in_reg, fade_out_reg;

    logic                                 in_valid_reg, in_valid_next;
    logic [psss_pkg::MODE_W-1:0]          mode_reg;
    logic [FRAME_BITS-1:0]                frame_reg;
    logic signed [psss_pkg::DELAY_W-1:0]  delay_reg;
    logic                                 cancel_reg;

    logic              fire, can_load;
    psss_pkg::result_t result, m_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg  <= psss_pkg::QUANTUM_RESET;
            fade_in_reg  <= psss_pkg::FADE_RESET;
            fade_out_reg <= psss_pkg::FADE_RESET;
        end else if (cfg_valid) begin
            unique case (psss_pkg::cfg_index_t'(cfg_index))
                psss_pkg::CFG_QUANTUM:  quantum_reg  <= cfg_data;
                psss_pkg::CFG_FADE_IN:  fade_in_reg  <= cfg_data;
                psss_pkg::CFG_FADE_OUT: fade_out_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register frees up in the same cycle its item moves to the result register
    assign fire          = in_valid_reg && can_load;
    assign s_ready       = !in_valid_reg || fire;
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg   <= s_mode;
            frame_reg  <= s_current_frame[FRAME_BITS-1:0];
            delay_reg  <= s_delay_frames;
            cancel_reg <= s_cancel;
        end
    end

    psss_sched #(
        .FRAME_BITS(FRAME_BITS)
    ) u_sched (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (fire),
        .mode            (mode_reg),
        .frame           (frame_reg),
        .delay_frames    (delay_reg),
        .cancel          (cancel_reg),
        .quantum_length  (quantum_reg),
        .fade_in_length  (fade_in_reg),
        .fade_out_length (fade_out_reg),
        .result          (result)
    );

    psss_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (result),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_processed       = m_result.processed;
    assign m_phase           = m_result.phase;
    assign m_render_offset   = m_result.render_offset;
    assign m_render_length   = m_result.render_length;
    assign m_silence_all     = m_result.silence_all;
    assign m_fade_in_active  = m_result.fade_in_active;
    assign m_fade_in_end     = m_result.fade_in_end;
    assign m_fade_out_active = m_result.fade_out_active;
    assign m_fade_out_start  = m_result.fade_out_start;
    assign m_fade_out_end    = m_result.fade_out_end;
    assign m_ended_event     = m_result.ended_event;
    assign m_start_notice    = m_result.start_notice;

endmodule

@@ sv/psss_sched.sv @@
module psss_sched #(
    parameter int FRAME_BITS = psss_pkg::FRAME_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 advance,
    input  logic [psss_pkg::MODE_W-1:0]          mode,
    input  logic [FRAME_BITS-1:0]                frame,
    input  logic signed [psss_pkg::DELAY_W-1:0]  delay_frames,
    input  logic                                 cancel,
    input  logic [psss_pkg::LEN_W-1:0]           quantum_length,
    input  logic [psss_pkg::LEN_W-1:0]           fade_in_length,
    input  logic [psss_pkg::LEN_W-1:0]           fade_out_length,
    output psss_pkg::result_t                    result
);

    localparam int MAG_W = psss_pkg::DELAY_W - 1;
    localparam int SUM_W = ((FRAME_BITS > MAG_W) ? FRAME_BITS : MAG_W) + 1;
    localparam logic [FRAME_BITS-1:0] NEVER = '1;
    localparam int LW = psss_pkg::LEN_W;
    localparam int OW = psss_pkg::OFF_W;

    psss_pkg::phase_t phase_reg, phase_next;
    logic [FRAME_BITS-1:0] last_epoch_reg, last_epoch_next;
    logic [FRAME_BITS-1:0] start_frame_reg, start_frame_next;
    logic [FRAME_BITS-1:0] stop_frame_reg, stop_frame_next;

    logic [LW-1:0] q, fi, fo;
    logic [MAG_W-1:0] delay_mag;
    logic [SUM_W-1:0] sum;
    logic [FRAME_BITS-1:0] epoch_sum;

    logic fresh, start_due, start_near, stop_due, stop_near, stop_reach;
    logic [FRAME_BITS-1:0] start_diff, stop_diff;

    logic tick_ok, ended, notice, silent;
    logic [OW-1:0] off;
    logic [LW-1:0] len;
    logic [LW:0]   fi_sum;
    logic [LW-1:0] fi_end, tail_start, fo_start;

    // register values out of range are clamped on use
    assign q  = (quantum_length > psss_pkg::MAX_QUANTUM) ? psss_pkg::MAX_QUANTUM :
                (quantum_length == '0) ? LW'(1) : quantum_length;
    assign fi = (fade_in_length > psss_pkg::MAX_QUANTUM) ? psss_pkg::MAX_QUANTUM
                                                          : fade_in_length;
    assign fo = (fade_out_length > psss_pkg::MAX_QUANTUM) ? psss_pkg::MAX_QUANTUM
                                                           : fade_out_length;

    // epoch plus delay, negative delay as zero, saturating at never
    assign delay_mag = delay_frames[psss_pkg::DELAY_W-1] ? '0 : delay_frames[MAG_W-1:0];
    assign sum       = SUM_W'(last_epoch_reg) + SUM_W'(delay_mag);
    assign epoch_sum = (sum[SUM_W-1:FRAME_BITS] != '0) ? NEVER : sum[FRAME_BITS-1:0];

    assign fresh      = frame > last_epoch_reg;
    assign start_due  = start_frame_reg <= frame;
    assign start_diff = start_frame_reg - frame;
    assign start_near = !start_due && (start_diff < FRAME_BITS'(q));
    assign stop_due   = stop_frame_reg <= frame;
    assign stop_diff  = stop_frame_reg - frame;
    assign stop_near  = !stop_due && (stop_diff < FRAME_BITS'(q));
    assign stop_reach = stop_due || (stop_diff <= FRAME_BITS'(q));

    always_comb begin
        phase_next       = phase_reg;
        last_epoch_next  = last_epoch_reg;
        start_frame_next = start_frame_reg;
        stop_frame_next  = stop_frame_reg;
        off              = '0;
        len              = q;
        tick_ok          = 1'b0;
        ended            = 1'b0;
        notice           = 1'b0;
        unique case (psss_pkg::mode_t'(mode))
            psss_pkg::MODE_TICK: begin
                if (fresh) begin
                    tick_ok         = 1'b1;
                    last_epoch_next = frame;
                    unique case (phase_reg) inside
                        psss_pkg::PH_SCHED: begin
                            if (start_due) begin
                                phase_next = psss_pkg::PH_FADEIN;
                            end else if (start_near) begin
                                off        = start_diff[OW-1:0];
                                len        = q - LW'(start_diff[OW-1:0]);
                                phase_next = psss_pkg::PH_FADEIN;
                            end
                        end
                        psss_pkg::PH_FADEIN, psss_pkg::PH_PLAYING: begin
                            phase_next = psss_pkg::PH_PLAYING;
                            if (stop_due) begin
                                phase_next = psss_pkg::PH_STOPPING;
                            end else if (stop_near) begin
                                len        = stop_diff[LW-1:0];
                                phase_next = psss_pkg::PH_STOPPING;
                            end
                        end
                        psss_pkg::PH_STOPPING: begin
                            if (stop_reach) begin
                                stop_frame_next = NEVER;
                                phase_next      = psss_pkg::PH_UNSCHED;
                                ended           = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            psss_pkg::MODE_START: begin
                notice = 1'b1;
                if (phase_reg != psss_pkg::PH_SCHED && phase_reg != psss_pkg::PH_PLAYING) begin
                    stop_frame_next = NEVER;
                    if (cancel) begin
                        if (phase_reg == psss_pkg::PH_STOPPING ||
                            phase_reg == psss_pkg::PH_RESETTING) begin
                            phase_next = psss_pkg::PH_PLAYING;
                        end
                    end else begin
                        start_frame_next = epoch_sum;
                        phase_next       = psss_pkg::PH_SCHED;
                    end
                end
            end
            psss_pkg::MODE_STOP: begin
                if (phase_reg != psss_pkg::PH_STOPPING && phase_reg != psss_pkg::PH_RESETTING &&
                    phase_reg != psss_pkg::PH_FINISHING && phase_reg != psss_pkg::PH_FINISHED) begin
                    stop_frame_next = cancel ? NEVER : epoch_sum;
                end
            end
            psss_pkg::MODE_RESET: begin
                start_frame_next = NEVER;
                stop_frame_next  = NEVER;
                if (phase_reg != psss_pkg::PH_UNSCHED) begin
                    phase_next = psss_pkg::PH_RESETTING;
                end
            end
            psss_pkg::MODE_FINISH: begin
                if (phase_reg != psss_pkg::PH_FINISHED) begin
                    phase_next = psss_pkg::PH_FINISHING;
                end
                ended = 1'b1;
            end
            default: ;
        endcase
    end

    // fade windows, clamped to the quantum
    assign silent     = (phase_next == psss_pkg::PH_UNSCHED) || (phase_next == psss_pkg::PH_SCHED) ||
                        (phase_next == psss_pkg::PH_FINISHED);
    assign fi_sum     = (LW+1)'(off) + (LW+1)'(fi);
    assign fi_end     = (fi_sum > (LW+1)'(q)) ? q : fi_sum[LW-1:0];
    assign tail_start = LW'(off) + len;
    assign fo_start   = (tail_start >= fo) ? (tail_start - fo) : '0;

    always_comb begin
        result              = '0;
        result.ended_event  = ended;
        result.start_notice = notice;
        if (tick_ok) begin
            result.processed = 1'b1;
            result.phase     = psss_pkg::phase_code(phase_next);
            if (silent) begin
                result.silence_all = 1'b1;
            end else begin
                result.render_offset = off;
                result.render_length = len;
                if ((off != '0 || phase_next == psss_pkg::PH_FADEIN) && fi_end > LW'(off)) begin
                    result.fade_in_active = 1'b1;
                    result.fade_in_end    = fi_end;
                end
                if ((tail_start != q || phase_next == psss_pkg::PH_STOPPING) &&
                    tail_start > fo_start) begin
                    result.fade_out_active = 1'b1;
                    result.fade_out_start  = fo_start;
                    result.fade_out_end    = tail_start;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= psss_pkg::PH_UNSCHED;
            last_epoch_reg  <= '0;
            start_frame_reg <= NEVER;
            stop_frame_reg  <= NEVER;
        end else if (advance) begin
            phase_reg       <= phase_next;
            last_epoch_reg  <= last_epoch_next;
            start_frame_reg <= start_frame_next;
            stop_frame_reg  <= stop_frame_next;
        end
    end

endmodule

@@ sv/psss_out.sv @@
module psss_out (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  psss_pkg::result_t result,
    output logic              can_load,
    output logic              m_valid,
    input  logic              m_ready,
    output psss_pkg::result_t m_result
);

    logic              valid_reg, valid_next;
    psss_pkg::result_t result_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

@@ sv/psss_check.sv @@
module psss_check (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_processed,
    input logic [psss_pkg::PHASE_W-1:0]  m_phase,
    input logic [psss_pkg::OFF_W-1:0]    m_render_offset,
    input logic [psss_pkg::LEN_W-1:0]    m_render_length,
    input logic                          m_silence_all,
    input logic                          m_fade_in_active,
    input logic [psss_pkg::LEN_W-1:0]    m_fade_in_end,
    input logic                          m_fade_out_active,
    input logic [psss_pkg::LEN_W-1:0]    m_fade_out_start,
    input logic [psss_pkg::LEN_W-1:0]    m_fade_out_end
);

    localparam int LW = psss_pkg::LEN_W;

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_phase) && $stable(m_render_length))
        else $error("result changed while stalled");

    // commands and stale ticks carry no render information
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_processed |-> m_phase == '0 && m_render_length == '0 &&
            !m_silence_all && !m_fade_in_active && !m_fade_out_active)
        else $error("unprocessed result carries render fields");

    // silent quantum has no rendered span and no fades
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_silence_all |-> m_processed && m_render_length == '0 &&
            m_render_offset == '0 && !m_fade_in_active && !m_fade_out_active)
        else $error("silent quantum with render fields");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fade_in_active |-> m_fade_in_end > LW'(m_render_offset))
        else $error("empty fade-in window");

    // fade-out ends where rendering ends
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fade_out_active |-> m_fade_out_start < m_fade_out_end &&
            m_fade_out_end == LW'(m_render_offset) + m_render_length)
        else $error("fade-out window misplaced");

endmodule

bind playback_start_stop_scheduler psss_check u_psss_check (.*);
